// File: rtl/lsad_pkg.sv
// shared types and constants of the light sensor auto dimmer
// register bank layout, reset values and the stage-one item record
// no dependencies
package lsad_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic KIND_SENSOR = 1'b0;
    localparam logic KIND_POT    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSOR_FLOOR      = 3'd0,
        CFG_SENSOR_CEILING    = 3'd1,
        CFG_DARK_LEVEL        = 3'd2,
        CFG_AUTO_DUTY_MIN     = 3'd3,
        CFG_AUTO_DUTY_MAX     = 3'd4,
        CFG_POT_AUTO_OFF      = 3'd5,
        CFG_POT_MANUAL_TOP    = 3'd6,
        CFG_POT_MANUAL_BOTTOM = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sensor_floor;
        logic [SAMPLE_W-1:0] sensor_ceiling;
        logic [SAMPLE_W-1:0] dark_level;
        logic [SAMPLE_W-1:0] auto_duty_min;
        logic [SAMPLE_W-1:0] auto_duty_max;
        logic [SAMPLE_W-1:0] pot_auto_off;
        logic [SAMPLE_W-1:0] pot_manual_top;
        logic [SAMPLE_W-1:0] pot_manual_bottom;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        sensor_floor:      8'd5,
        sensor_ceiling:    8'd68,
        dark_level:        8'd7,
        auto_duty_min:     8'd128,
        auto_duty_max:     8'd255,
        pot_auto_off:      8'd250,
        pot_manual_top:    8'd192,
        pot_manual_bottom: 8'd64
    };

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] average;
        logic [SAMPLE_W-1:0] pot;
    } t_stage;

endpackage

// File: rtl/lsad_cell.sv
// one stage of the sample window: holds a sample and hands it on when shifted
// depends on lsad_pkg
module lsad_cell
    import lsad_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic [SAMPLE_W-1:0] i_din,
    output logic [SAMPLE_W-1:0] o_dout
);

    logic [SAMPLE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_din;
        end
    end

    assign o_dout = r_data;

endmodule

// File: rtl/lsad_window.sv
// sample window: a row of lsad_cell stages with a running sum and the
// average of the window plus the incoming sample; depends on lsad_pkg, lsad_cell
module lsad_window
    import lsad_pkg::*;
#(
    parameter int DEPTH = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic [SAMPLE_W-1:0] o_average
);

    localparam int DIVISOR = DEPTH + 1;
    localparam int DIV_L   = $clog2(DIVISOR);
    localparam int SUM_W   = SAMPLE_W + DIV_L;
    localparam int DIV_S   = SUM_W + DIV_L;
    localparam longint unsigned DIV_M =
        ((longint'(1) << DIV_S) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
    localparam logic [SUM_W:0] MUL_K = DIV_M[SUM_W:0];

    logic [SAMPLE_W-1:0] w_tap [DEPTH+1];
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic [SUM_W-1:0]    w_total;
    logic [2*SUM_W:0]    w_prod;

    assign w_tap[DEPTH] = i_sample;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        lsad_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_din   (w_tap[k+1]),
            .o_dout  (w_tap[k])
        );
    end

    // oldest sample sits in the first cell
    assign w_total = r_sum + SUM_W'(i_sample);
    assign n_sum   = w_total - SUM_W'(w_tap[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_shift) begin
            r_sum <= n_sum;
        end
    end

    // divide by the stored samples plus one (DEPTH + 1) through a reciprocal multiply
    assign w_prod    = {{(SUM_W+1){1'b0}}, w_total} * {{SUM_W{1'b0}}, MUL_K};
    assign o_average = w_prod[DIV_S +: SAMPLE_W];

endmodule

// File: rtl/lsad_map.sv
// output stage: maps the average to duty, applies pot bands and holds
// duty, night mode and last average; depends on lsad_pkg
module lsad_map
    import lsad_pkg::*;
#(
    parameter int AUTO_SEPARATION = 5,
    parameter int AUTO_SHIFT      = 1,
    parameter int MANUAL_SHIFT    = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_stage              i_item,
    input  t_cfg                i_cfg,
    output logic [SAMPLE_W-1:0] o_duty,
    output logic                o_night,
    output logic [SAMPLE_W-1:0] o_average
);

    localparam int WIDE_W = SAMPLE_W + 8;
    localparam logic [SAMPLE_W-1:0] SEP = AUTO_SEPARATION[SAMPLE_W-1:0];
    localparam logic [SAMPLE_W-1:0] FULL = '1;

    logic [SAMPLE_W-1:0] r_duty, n_duty;
    logic                r_night, n_night;
    logic [SAMPLE_W-1:0] r_avg, n_avg;

    logic [SAMPLE_W-1:0] w_clamp;
    logic [SAMPLE_W-1:0] w_offs;
    logic [WIDE_W-1:0]   w_auto;
    logic [SAMPLE_W-1:0] w_auto_sat;
    logic [WIDE_W-1:0]   w_man;
    logic [SAMPLE_W-1:0] w_man_sat;
    logic                w_dark;

    always_comb begin
        w_clamp = (i_item.average > i_cfg.sensor_ceiling) ? i_cfg.sensor_ceiling
                                                          : i_item.average;
        w_offs  = (w_clamp > i_cfg.sensor_floor) ? (w_clamp - i_cfg.sensor_floor) : '0;
        w_auto  = (WIDE_W'(w_offs) << AUTO_SHIFT) + WIDE_W'(i_cfg.auto_duty_min);
        w_auto_sat = (w_auto > WIDE_W'(i_cfg.auto_duty_max)) ? i_cfg.auto_duty_max
                                                             : w_auto[SAMPLE_W-1:0];
        w_dark  = i_item.average < i_cfg.dark_level;
        w_man   = WIDE_W'(i_item.sample - i_cfg.pot_manual_bottom) << MANUAL_SHIFT;
        w_man_sat = (w_man > WIDE_W'(FULL)) ? FULL : w_man[SAMPLE_W-1:0];
    end

    always_comb begin
        n_duty  = r_duty;
        n_night = r_night;
        n_avg   = r_avg;
        if (i_item.kind == KIND_SENSOR) begin
            n_avg = i_item.average;
            if (i_item.pot < i_cfg.pot_manual_bottom) begin
                n_duty  = w_auto_sat;
                n_night = (i_item.pot > SEP) && w_dark;
            end else if (i_item.pot < i_cfg.pot_auto_off) begin
                n_night = w_dark;
            end else begin
                n_night = 1'b0;
            end
        end else begin
            if (i_item.sample >= i_cfg.pot_manual_top) begin
                n_duty = FULL;
            end else if (i_item.sample >= i_cfg.pot_manual_bottom) begin
                n_duty = w_man_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty  <= '0;
            r_night <= 1'b0;
            r_avg   <= '0;
        end else if (i_load) begin
            r_duty  <= n_duty;
            r_night <= n_night;
            r_avg   <= n_avg;
        end
    end

    assign o_duty    = r_duty;
    assign o_night   = r_night;
    assign o_average = r_avg;

endmodule

// File: rtl/light_sensor_auto_dimmer.sv
// light sensor auto dimmer top level: register bank, handshakes and stage one
// depends on lsad_pkg, lsad_window, lsad_map
// an accepted item is registered in stage one, and its result is then
// registered in stage two, which drives the result outputs
// throughput: one item per cycle; window sum and reciprocal multiply feed stage
// one, the duty mapping fills stage two; input stalls only while both are held
// synchronous active-low reset clears the window, sum, pot level, duty,
// night mode and average, and loads register reset values at once
module light_sensor_auto_dimmer
    import lsad_pkg::*;
#(
    parameter int STORED_SAMPLES  = 15,
    parameter int AUTO_SEPARATION = 5,
    parameter int AUTO_SHIFT      = 1,
    parameter int MANUAL_SHIFT    = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_W-1:0]  i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic [SAMPLE_W-1:0]  i_sample,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [SAMPLE_W-1:0]  o_duty,
    output logic                 o_night_mode,
    output logic [SAMPLE_W-1:0]  o_light_average
);

    t_cfg                r_cfg;
    logic                r_s1_valid, n_s1_valid;
    t_stage              r_s1;
    logic [SAMPLE_W-1:0] r_pot;
    logic                r_out_valid, n_out_valid;

    logic                w_out_free;
    logic                w_s1_adv;
    logic                w_in_xfer;
    logic                w_shift;
    logic [SAMPLE_W-1:0] w_floored;
    logic [SAMPLE_W-1:0] w_average;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SENSOR_FLOOR:      r_cfg.sensor_floor      <= i_cfg_data;
                CFG_SENSOR_CEILING:    r_cfg.sensor_ceiling    <= i_cfg_data;
                CFG_DARK_LEVEL:        r_cfg.dark_level        <= i_cfg_data;
                CFG_AUTO_DUTY_MIN:     r_cfg.auto_duty_min     <= i_cfg_data;
                CFG_AUTO_DUTY_MAX:     r_cfg.auto_duty_max     <= i_cfg_data;
                CFG_POT_AUTO_OFF:      r_cfg.pot_auto_off      <= i_cfg_data;
                CFG_POT_MANUAL_TOP:    r_cfg.pot_manual_top    <= i_cfg_data;
                CFG_POT_MANUAL_BOTTOM: r_cfg.pot_manual_bottom <= i_cfg_data;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || i_ready;
    assign w_s1_adv   = r_s1_valid && w_out_free;
    assign o_ready    = !r_s1_valid || w_out_free;
    assign w_in_xfer  = i_valid && o_ready;
    assign w_shift    = w_in_xfer && (i_kind == KIND_SENSOR);
    assign w_floored  = (i_sample < r_cfg.sensor_floor) ? r_cfg.sensor_floor : i_sample;

    lsad_window #(
        .DEPTH (STORED_SAMPLES)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_shift   (w_shift),
        .i_sample  (w_floored),
        .o_average (w_average)
    );

    always_comb begin
        n_s1_valid  = w_in_xfer ? 1'b1 : (w_s1_adv ? 1'b0 : r_s1_valid);
        n_out_valid = w_s1_adv ? 1'b1 : (i_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pot       <= '0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (w_in_xfer && (i_kind == KIND_POT)) begin
                r_pot <= i_sample;
            end
        end
    end

    // pot level captured as it stood before this item
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1.kind    <= i_kind;
            r_s1.sample  <= i_sample;
            r_s1.average <= w_average;
            r_s1.pot     <= r_pot;
        end
    end

    lsad_map #(
        .AUTO_SEPARATION (AUTO_SEPARATION),
        .AUTO_SHIFT      (AUTO_SHIFT),
        .MANUAL_SHIFT    (MANUAL_SHIFT)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_s1_adv),
        .i_item    (r_s1),
        .i_cfg     (r_cfg),
        .o_duty    (o_duty),
        .o_night   (o_night_mode),
        .o_average (o_light_average)
    );

    assign o_valid = r_out_valid;

endmodule
